FILE: rtl/ohr_pkg.sv
// ----------------------------------------------------------------------------
// ohr_pkg
// Shared types, sizes and helpers for the overwriting history ring.
// ----------------------------------------------------------------------------
package ohr_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned ELEM_W  = 32;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned ITEM_W  = 32;
  localparam int unsigned AGE_W   = 4;
  localparam int unsigned NCAP_W  = 5;
  localparam int unsigned COUNT_W = 5;

  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    K_ADD    = 2'd0,
    K_READ   = 2'd1,
    K_RESIZE = 2'd2,
    K_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_READ,
    S_REL_RD,
    S_REL_EMIT,
    S_CPY_RD,
    S_CPY_WR,
    S_FIN,
    S_EMPTY
  } state_e;

  typedef enum logic [2:0] {
    RS_WP,
    RS_AGE_IN,
    RS_AGE_Q,
    RS_REL,
    RS_CPY
  } rd_src_e;

  typedef enum logic [1:0] {
    EM_ADD,
    EM_READ,
    EM_REL,
    EM_NONE
  } emit_e;

  typedef struct packed {
    logic    accept;
    rd_src_e rd_src;
    logic    emit;
    emit_e   emit_sel;
    logic    last;
    logic    add_commit;
    logic    rel_step;
    logic    cpy_step;
    logic    fin_commit;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_e in_kind;
    kind_e kind;
    logic  out_free;
    logic  rel_done;
    logic  rel_last;
    logic  cpy_done;
    logic  released;
    logic  same_cap;
  } ctrl_stat_t;

  // slot of the entry of a given age, 0 being the newest
  function automatic logic [ADDR_W-1:0] slot_of_age(input logic [ADDR_W-1:0] wp,
                                                    input logic [CNT_W-1:0]  cap,
                                                    input logic [CNT_W-1:0]  age);
    logic [CNT_W:0] off;
    off = (CNT_W+1)'(wp) + (CNT_W+1)'(cap) - (CNT_W+1)'(1) - (CNT_W+1)'(age);
    if (off >= (CNT_W+1)'(cap)) begin
      off = off - (CNT_W+1)'(cap);
    end
    return off[ADDR_W-1:0];
  endfunction

endpackage

FILE: rtl/ohr_in_if.sv
// ----------------------------------------------------------------------------
// ohr_in_if
// Command channel of the history ring: valid/ready plus the command item.
// ----------------------------------------------------------------------------
interface ohr_in_if import ohr_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ITEM_W-1:0] item_in;
  logic [AGE_W-1:0]  age;
  logic [NCAP_W-1:0] resize_cap;

  modport source (output valid, output kind, output item_in, output age,
                  output resize_cap, input ready);
  modport sink   (input valid, input kind, input item_in, input age,
                  input resize_cap, output ready);

endinterface

FILE: rtl/ohr_out_if.sv
// ----------------------------------------------------------------------------
// ohr_out_if
// Result channel of the history ring: valid/ready plus the result item.
// ----------------------------------------------------------------------------
interface ohr_out_if import ohr_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [ITEM_W-1:0]  item_out;
  logic               has_item;
  logic               age_error;
  logic [COUNT_W-1:0] count;
  logic               last;

  modport source (output valid, output item_out, output has_item, output age_error,
                  output count, output last, input ready);
  modport sink   (input valid, input item_out, input has_item, input age_error,
                  input count, input last, output ready);

endinterface

FILE: rtl/overwriting_history_ring.sv
// ----------------------------------------------------------------------------
// overwriting_history_ring
// History ring of handles with overwrite-on-full, read by age, resize, clear.
// ----------------------------------------------------------------------------
// One item is handled at a time. Add and read pass through the accept
// cycle, in which the history RAM is addressed, and then the add or read
// state, in which its registered read data is loaded into the result register.
// Resize and clear walk the RAM through its single read port: each released
// entry is read and then emitted, and each entry kept by a resize is read and
// then copied into the other RAM bank, oldest first, before a closing state.
// Any cycle in which the result register is still held by the sink stretches
// the steps that emit a result. A new item is taken while the last result of
// the previous one is waiting in the result register.
module overwriting_history_ring import ohr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ohr_in_if.sink    in_i,
  ohr_out_if.source res_o
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic       in_ready;

  ohr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ohr_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .in_kind_i       (in_i.kind),
    .in_item_i       (in_i.item_in),
    .in_age_i        (in_i.age),
    .in_ncap_i       (in_i.resize_cap),
    .res_valid_o     (res_o.valid),
    .res_ready_i     (res_o.ready),
    .res_item_o      (res_o.item_out),
    .res_has_item_o  (res_o.has_item),
    .res_age_error_o (res_o.age_error),
    .res_count_o     (res_o.count),
    .res_last_o      (res_o.last)
  );

  assign in_i.ready = in_ready;

endmodule

FILE: rtl/ohr_ctrl.sv
// ----------------------------------------------------------------------------
// ohr_ctrl
// Sequencer: steps the datapath through add, read, release and compaction.
// ----------------------------------------------------------------------------
module ohr_ctrl import ohr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.rd_src     = RS_WP;
    cmd_o.emit_sel   = EM_NONE;

    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.rd_src = (stat_i.in_kind == K_READ) ? RS_AGE_IN : RS_WP;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (stat_i.in_kind)
            K_ADD:   state_d = S_ADD;
            K_READ:  state_d = S_READ;
            default: state_d = S_REL_RD;
          endcase
        end
      end
      S_ADD: begin
        cmd_o.rd_src = RS_WP;
        if (stat_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_sel   = EM_ADD;
          cmd_o.last       = 1'b1;
          cmd_o.add_commit = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.rd_src = RS_AGE_Q;
        if (stat_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EM_READ;
          cmd_o.last     = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_REL_RD: begin
        cmd_o.rd_src = RS_REL;
        if (!stat_i.rel_done) begin
          state_d = S_REL_EMIT;
        end else if (stat_i.kind == K_CLEAR) begin
          state_d = S_FIN;
        end else if (stat_i.same_cap) begin
          state_d = S_EMPTY;
        end else begin
          state_d = S_CPY_RD;
        end
      end
      S_REL_EMIT: begin
        cmd_o.rd_src = RS_REL;
        if (stat_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EM_REL;
          cmd_o.last     = stat_i.rel_last;
          cmd_o.rel_step = 1'b1;
          state_d        = S_REL_RD;
        end
      end
      S_CPY_RD: begin
        cmd_o.rd_src = RS_CPY;
        state_d      = stat_i.cpy_done ? S_FIN : S_CPY_WR;
      end
      S_CPY_WR: begin
        cmd_o.rd_src   = RS_CPY;
        cmd_o.cpy_step = 1'b1;
        state_d        = S_CPY_RD;
      end
      S_FIN: begin
        if (stat_i.released) begin
          cmd_o.fin_commit = 1'b1;
          state_d          = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_sel   = EM_NONE;
          cmd_o.last       = 1'b1;
          cmd_o.fin_commit = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (stat_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EM_NONE;
          cmd_o.last     = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/ohr_dpath.sv
// ----------------------------------------------------------------------------
// ohr_dpath
// Ring pointers, two history RAM banks, release/copy counters, result register.
// ----------------------------------------------------------------------------
module ohr_dpath import ohr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output ctrl_stat_t         stat_o,
  input  logic [KIND_W-1:0]  in_kind_i,
  input  logic [ITEM_W-1:0]  in_item_i,
  input  logic [AGE_W-1:0]   in_age_i,
  input  logic [NCAP_W-1:0]  in_ncap_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [ITEM_W-1:0]  res_item_o,
  output logic               res_has_item_o,
  output logic               res_age_error_o,
  output logic [COUNT_W-1:0] res_count_o,
  output logic               res_last_o
);

  // ring state
  logic [ADDR_W-1:0] wp_q;
  logic [CNT_W-1:0]  held_q;
  logic [CNT_W-1:0]  cap_q;
  logic              bank_q;

  // latched item
  kind_e             kind_q;
  logic [ELEM_W-1:0] item_q;
  logic [CNT_W-1:0]  age_q;
  logic [CNT_W-1:0]  ncap_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              released_q;
  logic              same_cap_q;
  logic [CNT_W-1:0]  idx_q;
  logic [CNT_W-1:0]  cidx_q;

  // result register
  logic              out_valid_q;
  logic [ITEM_W-1:0] out_item_q;
  logic              out_has_q;
  logic              out_err_q;
  logic              out_last_q;

  // history RAM banks
  logic [ELEM_W-1:0] mem0_q [DEPTH];
  logic [ELEM_W-1:0] mem1_q [DEPTH];
  logic [ELEM_W-1:0] rd0_q, rd1_q, rdata;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [ELEM_W-1:0] wdata;
  logic              we0, we1, add_we;

  kind_e             in_kind;
  logic [CNT_W-1:0]  ncap_sat, cnt_next;
  logic [CNT_W-1:0]  wp_inc;
  logic              full;

  assign in_kind = kind_e'(in_kind_i);
  assign full    = (cap_q != '0) && (held_q == cap_q);
  assign wp_inc  = CNT_W'(wp_q) + CNT_W'(1);

  always_comb begin
    if (32'(in_ncap_i) > DEPTH) begin
      ncap_sat = CNT_W'(DEPTH);
    end else begin
      ncap_sat = CNT_W'(in_ncap_i);
    end
  end

  always_comb begin
    case (in_kind)
      K_ADD:    cnt_next = ((cap_q != '0) && !full) ? held_q + CNT_W'(1) : held_q;
      K_READ:   cnt_next = held_q;
      K_RESIZE: cnt_next = (held_q < ncap_sat) ? held_q : ncap_sat;
      default:  cnt_next = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.rd_src)
      RS_WP:     raddr = wp_q;
      RS_AGE_IN: raddr = slot_of_age(wp_q, cap_q, CNT_W'(in_age_i));
      RS_AGE_Q:  raddr = slot_of_age(wp_q, cap_q, age_q);
      RS_REL:    raddr = slot_of_age(wp_q, cap_q, idx_q);
      RS_CPY:    raddr = slot_of_age(wp_q, cap_q, cnt_q - CNT_W'(1) - cidx_q);
      default:   raddr = wp_q;
    endcase
  end

  // adds go to the live bank; compaction fills the other one
  assign add_we = cmd_i.add_commit && (cap_q != '0);
  assign waddr  = add_we ? wp_q : cidx_q[ADDR_W-1:0];
  assign wdata  = add_we ? item_q : rdata;
  assign we0    = (add_we && !bank_q) || (cmd_i.cpy_step && bank_q);
  assign we1    = (add_we && bank_q) || (cmd_i.cpy_step && !bank_q);
  assign rdata  = bank_q ? rd1_q : rd0_q;

  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0_q[waddr] <= wdata;
    end
    rd0_q <= mem0_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we1) begin
      mem1_q[waddr] <= wdata;
    end
    rd1_q <= mem1_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      held_q <= '0;
      cap_q  <= CNT_W'(DEPTH);
      bank_q <= 1'b0;
    end else if (add_we) begin
      wp_q   <= (wp_inc >= cap_q) ? '0 : wp_inc[ADDR_W-1:0];
      held_q <= cnt_q;
    end else if (cmd_i.fin_commit) begin
      held_q <= cnt_q;
      if (kind_q == K_RESIZE) begin
        cap_q  <= ncap_q;
        wp_q   <= (cnt_q >= ncap_q) ? '0 : cnt_q[ADDR_W-1:0];
        bank_q <= !bank_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q     <= in_kind;
      item_q     <= in_item_i[ELEM_W-1:0];
      age_q      <= CNT_W'(in_age_i);
      ncap_q     <= ncap_sat;
      cnt_q      <= cnt_next;
      released_q <= cnt_next < held_q;
      same_cap_q <= ncap_sat == cap_q;
      idx_q      <= cnt_next;
      cidx_q     <= '0;
    end else begin
      if (cmd_i.rel_step) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (cmd_i.cpy_step) begin
        cidx_q <= cidx_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_last_q <= cmd_i.last;
      case (cmd_i.emit_sel)
        EM_ADD: begin
          out_has_q  <= full;
          out_err_q  <= 1'b0;
          out_item_q <= full ? ITEM_W'(rdata) : '0;
        end
        EM_READ: begin
          out_has_q  <= age_q < held_q;
          out_err_q  <= !(age_q < held_q);
          out_item_q <= (age_q < held_q) ? ITEM_W'(rdata) : '0;
        end
        EM_REL: begin
          out_has_q  <= 1'b1;
          out_err_q  <= 1'b0;
          out_item_q <= ITEM_W'(rdata);
        end
        default: begin
          out_has_q  <= 1'b0;
          out_err_q  <= 1'b0;
          out_item_q <= '0;
        end
      endcase
    end
  end

  // count is fixed per item, so it is taken straight from the latched value
  logic [CNT_W-1:0] out_cnt_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_cnt_q <= cnt_q;
    end
  end

  assign res_valid_o     = out_valid_q;
  assign res_item_o      = out_item_q;
  assign res_has_item_o  = out_has_q;
  assign res_age_error_o = out_err_q;
  assign res_count_o     = COUNT_W'(out_cnt_q);
  assign res_last_o      = out_last_q;

  assign stat_o.in_kind  = in_kind;
  assign stat_o.kind     = kind_q;
  assign stat_o.out_free = !out_valid_q || res_ready_i;
  assign stat_o.rel_done = idx_q == held_q;
  assign stat_o.rel_last = (idx_q + CNT_W'(1)) == held_q;
  assign stat_o.cpy_done = cidx_q == cnt_q;
  assign stat_o.released = released_q;
  assign stat_o.same_cap = same_cap_q;

endmodule

FILE: dv/overwriting_history_ring_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_history_ring_tb
// Drives add, read, resize and clear items into the history ring with random
// gaps and result stalls. A behavioural copy of the ring predicts every
// result item, and each result is checked in order against that prediction.
// ----------------------------------------------------------------------------
module overwriting_history_ring_tb;
  import ohr_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RAND_CMDS  = 480;

  typedef struct {
    kind_e             kind;
    logic [ITEM_W-1:0] item;
    logic [AGE_W-1:0]  age;
    logic [NCAP_W-1:0] ncap;
    int unsigned       gap;
    bit                drain;
  } cmd_t;

  typedef struct packed {
    logic [ITEM_W-1:0]  item_out;
    logic               has_item;
    logic               age_error;
    logic [COUNT_W-1:0] count;
    logic               last;
  } res_t;

  logic clk_i;
  logic rst_ni;

  ohr_in_if  cmd_if ();
  ohr_out_if res_if ();

  overwriting_history_ring dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .res_o  (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // behavioural ring
  logic [ITEM_W-1:0] ring_mem [DEPTH];
  int unsigned       ring_wp;
  int unsigned       ring_held;
  int unsigned       ring_cap;

  cmd_t        cmd_queue [$];
  res_t        due_results [$];
  cmd_t        on_bus;
  bit          busy;
  bit          gap_armed;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned checked;
  int unsigned errors;
  int unsigned idle_cycles;

  function automatic logic [ITEM_W-1:0] entry_of_age(input int unsigned a);
    int unsigned off;
    off = ring_wp + ring_cap - 1 - a;
    if (off >= ring_cap) begin
      off = off - ring_cap;
    end
    return ring_mem[off];
  endfunction

  function automatic res_t handle(input logic [ITEM_W-1:0] v, input logic has,
                                  input logic err);
    res_t r;
    r = '0;
    r.item_out  = v;
    r.has_item  = has;
    r.age_error = err;
    return r;
  endfunction

  function automatic void ring_apply(input cmd_t c);
    res_t              step_q [$];
    res_t              r;
    logic [ITEM_W-1:0] kept [DEPTH];
    int unsigned       ncap;
    int unsigned       keep;
    case (c.kind)
      K_ADD: begin
        if (ring_cap == 0) begin
          step_q.push_back(handle('0, 1'b0, 1'b0));
        end else begin
          if (ring_held == ring_cap) begin
            step_q.push_back(handle(ring_mem[ring_wp], 1'b1, 1'b0));
          end else begin
            step_q.push_back(handle('0, 1'b0, 1'b0));
          end
          ring_mem[ring_wp] = c.item;
          ring_wp++;
          if (ring_wp >= ring_cap) begin
            ring_wp = 0;
          end
          if (ring_held < ring_cap) begin
            ring_held++;
          end
        end
      end
      K_READ: begin
        if (c.age < ring_held) begin
          step_q.push_back(handle(entry_of_age(c.age), 1'b1, 1'b0));
        end else begin
          step_q.push_back(handle('0, 1'b0, 1'b1));
        end
      end
      K_RESIZE: begin
        ncap = (c.ncap > DEPTH) ? DEPTH : c.ncap;
        if (ncap != ring_cap) begin
          keep = (ring_held < ncap) ? ring_held : ncap;
          for (int i = 0; i < DEPTH; i++) begin
            kept[i] = '0;
          end
          for (int i = 0; i < keep; i++) begin
            kept[i] = entry_of_age(keep - 1 - i);
          end
          for (int i = keep; i < ring_held; i++) begin
            step_q.push_back(handle(entry_of_age(i), 1'b1, 1'b0));
          end
          ring_mem  = kept;
          ring_cap  = ncap;
          ring_held = keep;
          ring_wp   = (keep >= ncap) ? 0 : keep;
        end
      end
      K_CLEAR: begin
        for (int i = 0; i < ring_held; i++) begin
          step_q.push_back(handle(entry_of_age(i), 1'b1, 1'b0));
        end
        ring_held = 0;
      end
      default: ;
    endcase
    if (step_q.size() == 0) begin
      step_q.push_back(handle('0, 1'b0, 1'b0));
    end
    foreach (step_q[i]) begin
      r       = step_q[i];
      r.count = COUNT_W'(ring_held);
      r.last  = (i == step_q.size() - 1);
      due_results.push_back(r);
    end
  endfunction

  function automatic void queue_cmd(input kind_e k, input logic [ITEM_W-1:0] item,
                                    input logic [AGE_W-1:0] age,
                                    input logic [NCAP_W-1:0] ncap, input bit drain);
    cmd_t c;
    c.kind  = k;
    c.item  = item;
    c.age   = age;
    c.ncap  = ncap;
    c.drain = drain;
    c.gap   = ((cmd_queue.size() / 40) % 3 == 1) ? 0 : $urandom_range(0, 13);
    cmd_queue.push_back(c);
  endfunction

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid      <= 1'b0;
      cmd_if.kind       <= K_ADD;
      cmd_if.item_in    <= '0;
      cmd_if.age        <= '0;
      cmd_if.resize_cap <= '0;
      busy      = 1'b0;
      gap_armed = 1'b0;
      gap_left  = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        ring_apply(on_bus);
        busy = 1'b0;
      end
      if (!busy && cmd_queue.size() != 0) begin
        if (!gap_armed) begin
          gap_left  = cmd_queue[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
        end else if (!cmd_queue[0].drain || due_results.size() == 0) begin
          on_bus    = cmd_queue.pop_front();
          gap_armed = 1'b0;
          busy      = 1'b1;
        end
      end
      cmd_if.valid      <= busy;
      cmd_if.kind       <= on_bus.kind;
      cmd_if.item_in    <= on_bus.item;
      cmd_if.age        <= on_bus.age;
      cmd_if.resize_cap <= on_bus.ncap;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t exp;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = {res_if.item_out, res_if.has_item, res_if.age_error, res_if.count,
               res_if.last};
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result item_out=%h has=%b err=%b count=%0d last=%b",
                   $time, got.item_out, got.has_item, got.age_error, got.count, got.last);
          errors++;
        end else begin
          exp = due_results.pop_front();
          if (got !== exp) begin
            $display("%0t: mismatch expected item_out=%h has=%b err=%b count=%0d last=%b",
                     $time, exp.item_out, exp.has_item, exp.age_error, exp.count, exp.last);
            $display("%0t:          actual   item_out=%h has=%b err=%b count=%0d last=%b",
                     $time, got.item_out, got.has_item, got.age_error, got.count, got.last);
            errors++;
          end
        end
        checked++;
        hold_left = ((checked / 50) % 3 == 2) ? 0 : $urandom_range(0, 13);
      end else if (hold_left != 0) begin
        hold_left--;
      end
      res_if.ready <= (hold_left == 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned       sel;
    int unsigned       r;
    logic [ITEM_W-1:0] item;
    logic [AGE_W-1:0]  age;
    logic [NCAP_W-1:0] ncap;

    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.kind       = K_ADD;
    cmd_if.item_in    = '0;
    cmd_if.age        = '0;
    cmd_if.resize_cap = '0;
    res_if.ready      = 1'b0;
    on_bus            = '{K_ADD, '0, '0, '0, 0, 1'b0};
    checked           = 0;
    errors            = 0;
    idle_cycles       = 0;
    ring_wp           = 0;
    ring_held         = 0;
    ring_cap          = DEPTH;
    for (int i = 0; i < DEPTH; i++) begin
      ring_mem[i] = '0;
    end

    // directed
    queue_cmd(K_READ,   32'h1234_5678, 4'd0,  5'd9,  1'b0);  // read on empty ring
    queue_cmd(K_CLEAR,  32'h0,         4'd3,  5'd2,  1'b0);  // clear with nothing held
    queue_cmd(K_RESIZE, 32'h0,         4'd0,  5'd16, 1'b0);  // same capacity
    queue_cmd(K_RESIZE, 32'hdead_beef, 4'd7,  5'd3,  1'b0);
    queue_cmd(K_ADD,    32'h0000_0000, 4'd0,  5'd0,  1'b0);
    queue_cmd(K_ADD,    32'hffff_ffff, 4'd15, 5'd31, 1'b0);
    queue_cmd(K_ADD,    32'haaaa_aaaa, 4'd0,  5'd0,  1'b0);
    queue_cmd(K_ADD,    32'h5555_5555, 4'd0,  5'd0,  1'b0);  // evicts on full
    queue_cmd(K_READ,   32'h0,         4'd0,  5'd0,  1'b0);
    queue_cmd(K_READ,   32'h0,         4'd2,  5'd0,  1'b0);
    queue_cmd(K_READ,   32'h0,         4'd3,  5'd0,  1'b0);  // past count
    queue_cmd(K_READ,   32'h0,         4'd15, 5'd0,  1'b0);
    queue_cmd(K_RESIZE, 32'h0,         4'd0,  5'd31, 1'b0);  // saturates
    queue_cmd(K_ADD,    32'h8000_0001, 4'd0,  5'd0,  1'b0);
    queue_cmd(K_RESIZE, 32'h0,         4'd0,  5'd2,  1'b0);  // drops oldest two
    queue_cmd(K_READ,   32'h0,         4'd1,  5'd0,  1'b0);
    queue_cmd(K_RESIZE, 32'h0,         4'd0,  5'd0,  1'b0);  // releases all
    queue_cmd(K_ADD,    32'hcafe_f00d, 4'd0,  5'd0,  1'b0);  // zero capacity
    queue_cmd(K_READ,   32'h0,         4'd0,  5'd0,  1'b0);
    queue_cmd(K_RESIZE, 32'h0,         4'd0,  5'd17, 1'b0);  // saturates
    queue_cmd(K_ADD,    32'h0f0f_0f0f, 4'd0,  5'd0,  1'b0);
    queue_cmd(K_ADD,    32'hf0f0_f0f0, 4'd0,  5'd0,  1'b0);
    queue_cmd(K_CLEAR,  32'h0,         4'd0,  5'd0,  1'b0);
    queue_cmd(K_READ,   32'h0,         4'd0,  5'd0,  1'b0);

    // random
    for (int i = 0; i < RAND_CMDS; i++) begin
      sel  = $urandom_range(0, 99);
      item = $urandom;
      age  = AGE_W'($urandom);
      ncap = NCAP_W'($urandom);
      if (sel < 55) begin
        queue_cmd(K_ADD, item, age, ncap, (i % 150) == 0);
      end else if (sel < 85) begin
        if ($urandom_range(0, 1) == 0) begin
          age = AGE_W'($urandom_range(0, 3));
        end
        queue_cmd(K_READ, item, age, ncap, (i % 150) == 0);
      end else if (sel < 96) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          ncap = '0;
        end else if (r == 1) begin
          ncap = NCAP_W'($urandom_range(17, 31));
        end else begin
          ncap = NCAP_W'($urandom_range(1, 16));
        end
        queue_cmd(K_RESIZE, item, age, ncap, (i % 150) == 0);
      end else begin
        queue_cmd(K_CLEAR, item, age, ncap, (i % 150) == 0);
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_queue.size() != 0 || busy || due_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (60) @(posedge clk_i);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
